// ----- design/tlic_pkg.sv -----
// ----------------------------------------------------------------------------
// tlic_pkg: shared types and constants
// Opcodes, register map, sub-source fold masks and the item/result structs
// used by the two-level interrupt controller.
// ----------------------------------------------------------------------------
package tlic_pkg;

    // First interrupt number that selects a sub-source
    localparam int SUB_BASE = 32;
    localparam int SUB_W    = 16;

    // Main bit positions that sub-source groups fold into
    localparam int BIT_CAMERA  = 6;
    localparam int BIT_WDT_AUD = 9;
    localparam int BIT_UART2   = 15;
    localparam int BIT_UART1   = 23;
    localparam int BIT_UART0   = 28;
    localparam int BIT_ADC_TC  = 31;

    // Sub-pending group masks
    localparam logic [15:0] GRP_ADC_TC  = 16'h0600;
    localparam logic [15:0] GRP_UART2   = 16'h01c0;
    localparam logic [15:0] GRP_UART1   = 16'h0038;
    localparam logic [15:0] GRP_UART0   = 16'h0007;
    localparam logic [15:0] GRP_CAMERA  = 16'h1800;
    localparam logic [15:0] GRP_WDT_AUD = 16'h6000;

    // Reset values and fixed read codes
    localparam logic [31:0] MASK_RESET = 32'hffff_ffff;
    localparam logic [31:0] PRIO_RESET = 32'h0000_007f;
    localparam logic [31:0] NO_OFFSET  = 32'h0000_00ff;
    localparam logic [2:0]  WORD_BYTES = 3'd4;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_SRCPND  = 3'd0,
        REG_MODE    = 3'd1,
        REG_MASK    = 3'd2,
        REG_PRIO    = 3'd3,
        REG_INTPND  = 3'd4,
        REG_OFFSET  = 3'd5,
        REG_SUBPND  = 3'd6,
        REG_SUBMASK = 3'd7
    } reg_idx_t;

    // Config register indexes
    localparam logic CFG_EXT_VARIANT = 1'b0;

    typedef struct packed {
        op_t         op;
        logic [2:0]  access_bytes;
        reg_idx_t    reg_index;
        logic [31:0] wdata;
        logic [5:0]  source_num;
        logic        raise;
    } item_t;

    typedef struct packed {
        logic        fiq_level;
        logic        irq_level;
        logic        ok;
        logic [31:0] rdata;
    } result_t;

endpackage

// ----- design/tlic_core.sv -----
// ----------------------------------------------------------------------------
// tlic_core: controller register file and update logic
// Holds pending/mode/mask/priority/sub registers and the IRQ offset latch;
// applies one item per accept and forms its result in the same cycle.
// ----------------------------------------------------------------------------
module tlic_core
    import tlic_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  item_t   item,
    input  logic    ext_variant,
    output result_t result
);

    logic [31:0] src_pnd_reg, src_pnd_next;
    logic [31:0] mode_reg, mode_next;
    logic [31:0] mask_reg, mask_next;
    logic [31:0] prio_reg, prio_next;
    logic [15:0] sub_pnd_reg, sub_pnd_next;
    logic [15:0] sub_mask_reg, sub_mask_next;
    logic        ofs_valid_reg, ofs_valid_next;
    logic [4:0]  ofs_reg, ofs_next;

    // Next state and result for the presented item
    always_comb
    begin
        logic        recompute;
        logic [6:0]  sub_idx;
        logic [15:0] subs;
        logic [31:0] folded;
        logic [31:0] active;
        logic [4:0]  low_idx;

        src_pnd_next   = src_pnd_reg;
        mode_next      = mode_reg;
        mask_next      = mask_reg;
        prio_next      = prio_reg;
        sub_pnd_next   = sub_pnd_reg;
        sub_mask_next  = sub_mask_reg;
        ofs_valid_next = ofs_valid_reg;
        ofs_next       = ofs_reg;
        result.rdata   = '0;
        result.ok      = 1'b1;
        recompute      = 1'b0;
        sub_idx        = 7'({1'b0, item.source_num}) - 7'(SUB_BASE);

        case (item.op)
            OP_EVENT:
            begin
                if (int'(item.source_num) >= SUB_BASE)
                begin
                    if (sub_idx < 7'(SUB_W))
                        sub_pnd_next[sub_idx[3:0]] = item.raise;
                end
                else if (item.source_num < 6'd32)
                begin
                    src_pnd_next[item.source_num[4:0]] = item.raise;
                end
                recompute = 1'b1;
            end
            OP_READ:
            begin
                if (item.access_bytes != WORD_BYTES)
                    result.ok = 1'b0;
                else
                begin
                    case (item.reg_index)
                        REG_SRCPND:  result.rdata = src_pnd_reg;
                        REG_MODE:    result.rdata = mode_reg;
                        REG_MASK:    result.rdata = mask_reg;
                        REG_PRIO:    result.rdata = prio_reg;
                        REG_INTPND:  result.rdata = ofs_valid_reg ? (32'd1 << ofs_reg) : '0;
                        REG_OFFSET:  result.rdata = ofs_valid_reg ? 32'(ofs_reg) : NO_OFFSET;
                        REG_SUBPND:  result.rdata = 32'(sub_pnd_reg);
                        default:     result.rdata = 32'(sub_mask_reg);
                    endcase
                end
            end
            OP_WRITE:
            begin
                if (item.access_bytes != WORD_BYTES)
                    result.ok = 1'b0;
                else
                begin
                    recompute = 1'b1;
                    case (item.reg_index)
                        REG_SRCPND: src_pnd_next = src_pnd_reg & ~item.wdata;
                        REG_MODE:   mode_next = item.wdata;
                        REG_MASK:   mask_next = item.wdata;
                        REG_PRIO:   prio_next = item.wdata;
                        REG_INTPND:
                        begin
                            // acknowledge only the latched bit
                            if (ofs_valid_reg && item.wdata[ofs_reg])
                                ofs_valid_next = 1'b0;
                        end
                        REG_OFFSET:
                        begin
                            result.ok = 1'b0;
                            recompute = 1'b0;
                        end
                        REG_SUBPND: sub_pnd_next = sub_pnd_reg & ~item.wdata[15:0];
                        default:    sub_mask_next = item.wdata[15:0];
                    endcase
                end
            end
            default:
                result.ok = 1'b0;
        endcase

        // Fold sub-sources into main bits and refresh the IRQ latch
        subs   = sub_pnd_next & ~sub_mask_next;
        folded = '0;
        folded[BIT_UART0]  = 1'b1;
        folded[BIT_UART1]  = 1'b1;
        folded[BIT_UART2]  = 1'b1;
        folded[BIT_ADC_TC] = 1'b1;
        if (ext_variant)
        begin
            folded[BIT_CAMERA]  = 1'b1;
            folded[BIT_WDT_AUD] = 1'b1;
        end
        if (recompute)
        begin
            src_pnd_next = src_pnd_next & ~folded;
            src_pnd_next[BIT_ADC_TC] = src_pnd_next[BIT_ADC_TC] | (|(subs & GRP_ADC_TC));
            src_pnd_next[BIT_UART2]  = src_pnd_next[BIT_UART2]  | (|(subs & GRP_UART2));
            src_pnd_next[BIT_UART1]  = src_pnd_next[BIT_UART1]  | (|(subs & GRP_UART1));
            src_pnd_next[BIT_UART0]  = src_pnd_next[BIT_UART0]  | (|(subs & GRP_UART0));
            if (ext_variant)
            begin
                src_pnd_next[BIT_CAMERA] =
                    src_pnd_next[BIT_CAMERA] | (|(subs & GRP_CAMERA));
                src_pnd_next[BIT_WDT_AUD] =
                    src_pnd_next[BIT_WDT_AUD] | (|(subs & GRP_WDT_AUD));
            end
        end

        active  = src_pnd_next & ~mode_next & ~mask_next;
        low_idx = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (active[i])
                low_idx = 5'(i);
        end
        if (recompute && !ofs_valid_next && (active != '0))
        begin
            ofs_next       = low_idx;
            ofs_valid_next = 1'b1;
        end

        result.irq_level = ofs_valid_next;
        result.fiq_level = |(src_pnd_next & mode_next);
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_pnd_reg   <= '0;
            mode_reg      <= '0;
            mask_reg      <= MASK_RESET;
            prio_reg      <= PRIO_RESET;
            sub_pnd_reg   <= '0;
            sub_mask_reg  <= '1;
            ofs_valid_reg <= 1'b0;
            ofs_reg       <= '0;
        end
        else if (accept)
        begin
            src_pnd_reg   <= src_pnd_next;
            mode_reg      <= mode_next;
            mask_reg      <= mask_next;
            prio_reg      <= prio_next;
            sub_pnd_reg   <= sub_pnd_next;
            sub_mask_reg  <= sub_mask_next;
            ofs_valid_reg <= ofs_valid_next;
            ofs_reg       <= ofs_next;
        end
    end

endmodule

// ----- design/two_level_interrupt_controller.sv -----
// ----------------------------------------------------------------------------
// two_level_interrupt_controller: top level
// Interrupt controller with grouped sub-sources, driven by a beat stream of
// bus reads, bus writes and source events; one result beat per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per beat: tuser is the opcode (read, write,
//   source event); tdata carries access size, register index, write data,
//   source number and raise flag.
//   m_axis returns one result beat per input beat: read data, ok flag and
//   the IRQ and FIQ line levels after that item.
//   The APB port holds one register (extended sub-source groups, address 0);
//   write it only while the stream is idle.
// Results: each accepted beat's result is registered in the result buffer.
// Throughput: 1 beat per cycle while s_axis_tready is high; state updates in
//   the cycle of acceptance, so dependent items may follow back to back.
// Stall: a two-entry result buffer (output register plus skid register)
//   lets one more beat in while a result waits; s_axis_tready drops when
//   both entries are full.
// Reset: rst_n clears pending, mode, sub-pending and the offset latch, sets
//   masks to all ones and priority to 0x7f, and empties the result buffer.
// ----------------------------------------------------------------------------
module two_level_interrupt_controller
    import tlic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] access_bytes, [5:3] reg_index, [37:6] wdata, [43:38] source_num,
    // [44] raise, [47:45] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] rdata, [32] ok, [33] irq_level, [34] fiq_level, [39:35] zero
    output logic [39:0] m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    item_t   item;
    result_t core_res;
    logic    accept;
    logic    ext_variant_reg;

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    // Unpack input beat
    always_comb
    begin
        item.op           = op_t'(s_axis_tuser);
        item.access_bytes = s_axis_tdata[2:0];
        item.reg_index    = reg_idx_t'(s_axis_tdata[5:3]);
        item.wdata        = s_axis_tdata[37:6];
        item.source_num   = s_axis_tdata[43:38];
        item.raise        = s_axis_tdata[44];
    end

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    tlic_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .ext_variant (ext_variant_reg),
        .result      (core_res)
    );

    // Result buffer: output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= accept;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
            out_reg <= skid_valid_reg ? skid_reg : core_res;
        else if (accept)
            skid_reg <= core_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.fiq_level, out_reg.irq_level, out_reg.ok,
                            out_reg.rdata};

    // APB configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ext_variant_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && (paddr[2] == CFG_EXT_VARIANT))
            ext_variant_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_EXT_VARIANT) ? 32'(ext_variant_reg) : '0;

endmodule

// ----- tb/tlic_checker.sv -----
// ----------------------------------------------------------------------------
// tlic_checker: result predictor and scoreboard
// Watches the item stream, the result stream and the APB port of the
// two-level interrupt controller. Keeps its own copy of the controller
// state, predicts one result per accepted item and compares each result
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tlic_checker
    import tlic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [2:0] access_bytes, [5:3] reg_index, [37:6] wdata, [43:38] source_num,
    // [44] raise, [47:45] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] rdata, [32] ok, [33] irq_level, [34] fiq_level, [39:35] zero
    input  logic [39:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          pending_count
);

    localparam logic [2:0] EXT_ADDR = 3'(CFG_EXT_VARIANT) << 2;

    // Shadow copy of the controller state
    logic        ext_groups = 1'b0;
    logic [31:0] src_pend   = '0;
    logic [31:0] mode_word  = '0;
    logic [31:0] mask_word  = MASK_RESET;
    logic [31:0] prio_word  = PRIO_RESET;
    logic [15:0] sub_pend   = '0;
    logic [15:0] sub_mask   = '1;
    logic        off_valid  = 1'b0;
    logic [4:0]  cur_off    = '0;

    result_t resp_q[$];
    result_t want;
    result_t got;
    int      errors = 0;

    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--)
            if (v[i])
                idx = 5'(i);
        return idx;
    endfunction

    // Fold sub-sources into main bits, then try to latch a new IRQ offset
    function automatic void refresh_pending();
        logic [15:0] subs;
        logic [31:0] folded;
        logic [31:0] active;
        subs   = sub_pend & ~sub_mask;
        folded = '0;
        folded[BIT_UART0]  = 1'b1;
        folded[BIT_UART1]  = 1'b1;
        folded[BIT_UART2]  = 1'b1;
        folded[BIT_ADC_TC] = 1'b1;
        if (ext_groups)
        begin
            folded[BIT_CAMERA]  = 1'b1;
            folded[BIT_WDT_AUD] = 1'b1;
        end
        src_pend = src_pend & ~folded;
        if ((subs & GRP_ADC_TC) != 0) src_pend[BIT_ADC_TC] = 1'b1;
        if ((subs & GRP_UART2) != 0)  src_pend[BIT_UART2]  = 1'b1;
        if ((subs & GRP_UART1) != 0)  src_pend[BIT_UART1]  = 1'b1;
        if ((subs & GRP_UART0) != 0)  src_pend[BIT_UART0]  = 1'b1;
        if (ext_groups)
        begin
            if ((subs & GRP_CAMERA) != 0)  src_pend[BIT_CAMERA]  = 1'b1;
            if ((subs & GRP_WDT_AUD) != 0) src_pend[BIT_WDT_AUD] = 1'b1;
        end
        active = src_pend & ~mode_word & ~mask_word;
        if (!off_valid && active != 0)
        begin
            cur_off   = lowest_set(active);
            off_valid = 1'b1;
        end
    endfunction

    // Apply one item to the shadow state and return the result it causes
    function automatic result_t apply_item(input logic [1:0] op, input logic [2:0] nbytes,
                                           input logic [2:0] ridx, input logic [31:0] wd,
                                           input logic [5:0] num, input logic rs);
        result_t r;
        int      sub_idx;
        r       = '0;
        r.ok    = 1'b1;
        sub_idx = int'(num) - SUB_BASE;
        if (op == OP_EVENT)
        begin
            if (int'(num) >= SUB_BASE)
            begin
                if (sub_idx < SUB_W)
                    sub_pend[sub_idx] = rs;
            end
            else if (num < 32)
                src_pend[num[4:0]] = rs;
            refresh_pending();
        end
        else if (op == OP_NONE || nbytes != WORD_BYTES)
            r.ok = 1'b0;
        else if (op == OP_READ)
        begin
            case (ridx)
                REG_SRCPND:  r.rdata = src_pend;
                REG_MODE:    r.rdata = mode_word;
                REG_MASK:    r.rdata = mask_word;
                REG_PRIO:    r.rdata = prio_word;
                REG_INTPND:  r.rdata = off_valid ? (32'd1 << cur_off) : '0;
                REG_OFFSET:  r.rdata = off_valid ? {27'd0, cur_off} : NO_OFFSET;
                REG_SUBPND:  r.rdata = {16'd0, sub_pend};
                default:     r.rdata = {16'd0, sub_mask};
            endcase
        end
        else
        begin
            case (ridx)
                REG_SRCPND:  src_pend  = src_pend & ~wd;
                REG_MODE:    mode_word = wd;
                REG_MASK:    mask_word = wd;
                REG_PRIO:    prio_word = wd;
                REG_INTPND:
                begin
                    // ack only clears the latch when it names the latched bit
                    if (off_valid && wd[cur_off])
                        off_valid = 1'b0;
                end
                REG_OFFSET:  r.ok = 1'b0;
                REG_SUBPND:  sub_pend = sub_pend & ~wd[15:0];
                default:     sub_mask = wd[15:0];
            endcase
            if (r.ok)
                refresh_pending();
        end
        r.irq_level = off_valid;
        r.fiq_level = |(src_pend & mode_word);
        return r;
    endfunction

    // Scoreboard: compare result beats first, then record new items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_groups = 1'b0;
            src_pend   = '0;
            mode_word  = '0;
            mask_word  = MASK_RESET;
            prio_word  = PRIO_RESET;
            sub_pend   = '0;
            sub_mask   = '1;
            off_valid  = 1'b0;
            cur_off    = '0;
            resp_q.delete();
            pending_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.rdata     = m_axis_tdata[31:0];
                got.ok        = m_axis_tdata[32];
                got.irq_level = m_axis_tdata[33];
                got.fiq_level = m_axis_tdata[34];
                if (resp_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: rdata=%h ok=%b irq=%b fiq=%b",
                                 got.rdata, got.ok, got.irq_level, got.fiq_level);
                end
                else
                begin
                    want = resp_q.pop_front();
                    if (got.rdata !== want.rdata || got.ok !== want.ok ||
                        got.irq_level !== want.irq_level ||
                        got.fiq_level !== want.fiq_level)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("result mismatch: exp rdata=%h ok=%b irq=%b fiq=%b",
                                   want.rdata, want.ok, want.irq_level, want.fiq_level);
                            $display(" / got rdata=%h ok=%b irq=%b fiq=%b",
                                     got.rdata, got.ok, got.irq_level, got.fiq_level);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                resp_q.push_back(apply_item(s_axis_tuser, s_axis_tdata[2:0],
                                            s_axis_tdata[5:3], s_axis_tdata[37:6],
                                            s_axis_tdata[43:38], s_axis_tdata[44]));
            if (psel && penable && pwrite && pready && paddr == EXT_ADDR)
                ext_groups = pwdata[0];
            pending_count <= resp_q.size();
        end
        error_count <= errors;
    end

endmodule

// ----- tb/tb_two_level_interrupt_controller.sv -----
// ----------------------------------------------------------------------------
// tb_two_level_interrupt_controller: testbench top
// Drives a directed sequence and three random phases of reads, writes and
// source events into the controller, switching the extended sub-source
// groups between phases over APB, with random gaps and result stalls.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_two_level_interrupt_controller;
    import tlic_pkg::*;

    localparam int         LIMIT_CYCLES = 200000;
    localparam logic [2:0] EXT_ADDR     = 3'(CFG_EXT_VARIANT) << 2;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    logic no_idle     = 1'b0;

    two_level_interrupt_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tlic_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side stalls about 8% of cycles, except while no_idle is set
    always @(posedge clk)
    begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 8);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_two_level_interrupt_controller: FAIL");
            $finish;
        end
    end

    // One item beat; returns just after the edge that accepted it
    task automatic send_beat(input op_t op, input logic [2:0] nbytes, input logic [2:0] ridx,
                             input logic [31:0] wd, input logic [5:0] num, input logic rs);
        while (!no_idle && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'd0, rs, num, wd, ridx, nbytes};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // APB write of the extended-groups register: setup, then access
    task automatic cfg_write(input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= EXT_ADDR;
        pwdata  <= {31'($urandom_range(32'h7fff_ffff)), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random item, weighted toward well-formed traffic that reaches the IRQ latch
    task automatic send_random();
        int          pick;
        int          sel;
        op_t         op;
        logic [2:0]  nbytes;
        logic [2:0]  ridx;
        logic [31:0] wd;
        logic [5:0]  num;
        logic        rs;
        pick   = $urandom_range(99);
        op     = OP_READ;
        nbytes = WORD_BYTES;
        ridx   = 3'($urandom_range(7));
        wd     = $urandom;
        num    = 6'($urandom_range(47));
        rs     = 1'($urandom_range(1));
        if (pick < 45)
        begin
            op = OP_EVENT;
            if ($urandom_range(9) == 0)
                num = 6'($urandom_range(63));
            rs = ($urandom_range(99) < 60);
        end
        else if (pick < 75)
        begin
            op  = OP_WRITE;
            sel = $urandom_range(9);
            if (sel <= 2)
            begin
                ridx = REG_INTPND;
                wd   = ($urandom_range(3) == 0) ? 32'hffff_ffff
                                                : (32'd1 << $urandom_range(31));
            end
            else if (sel == 3)
            begin
                ridx = REG_SRCPND;
                wd   = $urandom & $urandom;
            end
            else if (sel == 4)
            begin
                ridx = REG_MODE;
                wd   = $urandom & $urandom & $urandom;
            end
            else if (sel == 5)
            begin
                ridx = REG_MASK;
                case ($urandom_range(3))
                    0:       wd = '0;
                    1:       wd = $urandom;
                    default: wd = $urandom & $urandom;
                endcase
            end
            else if (sel == 6)
            begin
                ridx = REG_SUBPND;
                wd   = $urandom & $urandom;
            end
            else if (sel == 7)
            begin
                ridx = REG_SUBMASK;
                wd   = $urandom & $urandom;
            end
            else if (sel == 8)
                ridx = REG_PRIO;
        end
        else if (pick >= 95)
        begin
            // noise: unused op or a wrong access size
            if ($urandom_range(1) == 0)
            begin
                op     = OP_NONE;
                nbytes = 3'($urandom_range(7));
            end
            else
            begin
                op     = op_t'($urandom_range(2));
                sel    = $urandom_range(6);
                nbytes = (sel >= 4) ? 3'(sel + 1) : 3'(sel);
            end
            num = 6'($urandom_range(63));
        end
        send_beat(op, nbytes, ridx, wd, num, rs);
    endtask

    // Main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_write(1'b0);

        // reset values of every register
        for (int r = 0; r < 8; r++)
            send_beat(OP_READ, WORD_BYTES, 3'(r), '0, '0, 1'b0);
        // wrong sizes and the unused op
        send_beat(OP_READ, 3'd1, REG_MODE, '0, '0, 1'b0);
        send_beat(OP_WRITE, 3'd0, REG_MASK, '0, '0, 1'b0);
        send_beat(OP_NONE, 3'd7, REG_SUBMASK, 32'hffff_ffff, 6'd63, 1'b1);
        // unmask all, bit 0 in FIQ mode
        send_beat(OP_WRITE, WORD_BYTES, REG_MASK, '0, '0, 1'b0);
        send_beat(OP_WRITE, WORD_BYTES, REG_MODE, 32'd1, '0, 1'b0);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd0, 1'b1);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd5, 1'b1);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd31, 1'b1);
        send_beat(OP_READ, WORD_BYTES, REG_INTPND, '0, '0, 1'b0);
        send_beat(OP_READ, WORD_BYTES, REG_OFFSET, '0, '0, 1'b0);
        // offset register is read-only
        send_beat(OP_WRITE, WORD_BYTES, REG_OFFSET, 32'hffff_ffff, '0, 1'b0);
        // ack that names another bit keeps the latch
        send_beat(OP_WRITE, WORD_BYTES, REG_INTPND, 32'd1, '0, 1'b0);
        send_beat(OP_WRITE, WORD_BYTES, REG_SRCPND, 32'hffff_ffff, '0, 1'b0);
        send_beat(OP_WRITE, WORD_BYTES, REG_INTPND, 32'hffff_ffff, '0, 1'b0);
        // ack with nothing latched
        send_beat(OP_WRITE, WORD_BYTES, REG_INTPND, 32'hffff_ffff, '0, 1'b0);
        // sub-sources: fold, unfolded watchdog/audio group, out-of-range index
        send_beat(OP_WRITE, WORD_BYTES, REG_SUBMASK, '0, '0, 1'b0);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd32, 1'b1);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd45, 1'b1);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd63, 1'b1);
        send_beat(OP_WRITE, WORD_BYTES, REG_SUBPND, 32'hffff_ffff, '0, 1'b0);
        send_beat(OP_WRITE, WORD_BYTES, REG_PRIO, 32'hffff_ffff, '0, 1'b0);
        send_beat(OP_EVENT, WORD_BYTES, REG_SRCPND, '0, 6'd0, 1'b0);

        // extended groups on, with one full pause mid-phase
        drain();
        cfg_write(1'b1);
        for (int i = 0; i < 220; i++)
        begin
            if (i == 110)
                drain();
            send_random();
        end

        // extended groups off
        drain();
        cfg_write(1'b0);
        for (int i = 0; i < 220; i++)
            send_random();

        // extended groups on, no idling on either side
        drain();
        cfg_write(1'b1);
        no_idle <= 1'b1;
        for (int i = 0; i < 210; i++)
            send_random();
        drain();
        no_idle <= 1'b0;

        repeat (4) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("tb_two_level_interrupt_controller: PASS");
        else
            $display("tb_two_level_interrupt_controller: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
design/tlic_pkg.sv
design/tlic_core.sv
design/two_level_interrupt_controller.sv
tb/tlic_checker.sv
tb/tb_two_level_interrupt_controller.sv
